// ===== rtl/numeric_literal_scanner_core_defines.svh =====
// assertion macros for the numeric literal scanner
// used by numeric_literal_scanner_core; needs no other file
`ifndef NUMERIC_LITERAL_SCANNER_CORE_DEFINES_SVH
`define NUMERIC_LITERAL_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define NLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/nls_pkg.sv =====
// types, character codes and digit helpers for the numeric literal scanner
// standalone package, no dependencies
`default_nettype none

package nls_pkg;

   typedef logic [1:0] radix_type;
   typedef logic [1:0] mode_type;

   // base codes as reported on the result
   localparam radix_type RADIX_TEN     = 2'd0;
   localparam radix_type RADIX_SIXTEEN = 2'd1;
   localparam radix_type RADIX_TWO     = 2'd2;
   localparam radix_type RADIX_EIGHT   = 2'd3;

   // scanner modes
   localparam mode_type MODE_IDLE = 2'd0;
   localparam mode_type MODE_ZERO = 2'd1;
   localparam mode_type MODE_INT  = 2'd2;
   localparam mode_type MODE_FRAC = 2'd3;

   // token kinds
   localparam logic KIND_INT   = 1'b0;
   localparam logic KIND_FLOAT = 1'b1;

   // character codes
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_B       = 8'h62;
   localparam logic [7:0] CH_O       = 8'h6F;
   localparam logic [7:0] CH_DOT     = 8'h2E;

   // digit value marker for a character that is no digit of the base
   localparam logic [4:0] NO_DIGIT = 5'd16;
   localparam logic [7:0] COUNT_MAX = 8'd255;

   // value of a character as a digit of the given base, or NO_DIGIT
   function automatic logic [4:0] digit_value(input logic [7:0] ch, input radix_type r);
      logic [4:0] v;
      logic [4:0] lim;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         v = 5'(ch - CH_ZERO);
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
         v = 5'(ch - CH_LOWER_A) + 5'd10;
      end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
         v = 5'(ch - CH_UPPER_A) + 5'd10;
      end else begin
         v = NO_DIGIT;
      end
      case (r)
         RADIX_TEN:     lim = 5'd10;
         RADIX_SIXTEEN: lim = 5'd16;
         RADIX_TWO:     lim = 5'd2;
         default:       lim = 5'd8;
      endcase
      return (v < lim) ? v : NO_DIGIT;
   endfunction

   // acc * base + d with four guard bits; nonzero guard bits mean a wrap
   function automatic logic [67:0] mul_add(input logic [63:0] acc, input radix_type r,
                                           input logic [3:0] d);
      logic [67:0] wide;
      logic [67:0] prod;
      wide = {4'b0, acc};
      case (r)
         RADIX_TEN:     prod = (wide << 3) + (wide << 1);
         RADIX_SIXTEEN: prod = wide << 4;
         RADIX_TWO:     prod = wide << 1;
         default:       prod = wide << 3;
      endcase
      return prod + {64'b0, d};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/numeric_literal_scanner_core.sv =====
// numeric literal scanner: one character per item, one token per literal
// uses nls_pkg and numeric_literal_scanner_core_defines.svh
`default_nettype none

// Takes one character per cycle and emits one token when a literal closes.
// A leading 0x, 0b or 0o selects base 16, 2 or 8, otherwise base 10; a '.'
// starts the fraction part, a second '.' closes the literal and is consumed
// (end_consumed 1), any other non-digit closes it and must be reread by the
// next scanner (end_consumed 0). The token appears on the rsp_ port in the
// cycle after the closing character is accepted. Each character is handled
// by a single 64-bit shift-add accumulate step, so the block sustains one
// item per cycle; req_ready drops only while a finished token waits and
// rsp_ready is low. Accumulators wrap modulo 2^64 and flag it.
module numeric_literal_scanner_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_ch,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_kind,
   output logic [63:0]             rsp_int_value,
   output logic [63:0]             rsp_frac_value,
   output logic [7:0]              rsp_frac_digits,
   output nls_pkg::radix_type      rsp_radix_code,
   output logic                    rsp_overflowed,
   output logic                    rsp_end_consumed
);
   import nls_pkg::*;

   `include "numeric_literal_scanner_core_defines.svh"

   // scan state
   mode_type    mode_ff, mode_in;
   radix_type   radix_ff, radix_in;
   logic [63:0] int_acc_ff, int_acc_in;
   logic [63:0] frac_acc_ff, frac_acc_in;
   logic [7:0]  frac_count_ff, frac_count_in;
   logic        wrap_ff, wrap_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [63:0] rsp_int_ff;
   logic [63:0] rsp_frac_ff;
   logic [7:0]  rsp_digits_ff;
   radix_type   rsp_radix_ff;
   logic        rsp_wrap_ff;
   logic        rsp_consumed_ff;

   logic        accept;
   logic        emit;
   logic        emit_kind;
   logic        emit_consumed;
   logic        step_active;
   mode_type    work_mode;
   logic [4:0]  digit;
   logic        is_digit;
   logic        is_dot;
   logic [67:0] int_sum;
   logic [67:0] frac_sum;

   // accept while the result register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // digit decode and both accumulate candidates
   assign digit    = digit_value(req_ch, radix_ff);
   assign is_digit = (digit != NO_DIGIT);
   assign is_dot   = (req_ch == CH_DOT);
   assign int_sum  = mul_add(int_acc_ff, radix_ff, digit[3:0]);
   assign frac_sum = mul_add(frac_acc_ff, radix_ff, digit[3:0]);

   // next state for one character
   always_comb begin
      mode_in       = mode_ff;
      radix_in      = radix_ff;
      int_acc_in    = int_acc_ff;
      frac_acc_in   = frac_acc_ff;
      frac_count_in = frac_count_ff;
      wrap_in       = wrap_ff;
      emit          = 1'b0;
      emit_kind     = KIND_INT;
      emit_consumed = 1'b0;
      step_active   = 1'b1;
      work_mode     = mode_ff;

      // literal start and prefix handling
      if (mode_ff == MODE_IDLE) begin
         if (req_ch == CH_ZERO) begin
            mode_in     = MODE_ZERO;
            step_active = 1'b0;
         end else begin
            work_mode = MODE_INT;
         end
      end else if (mode_ff == MODE_ZERO) begin
         if (req_ch == CH_X || req_ch == CH_B || req_ch == CH_O) begin
            radix_in    = (req_ch == CH_X) ? RADIX_SIXTEEN :
                          (req_ch == CH_B) ? RADIX_TWO : RADIX_EIGHT;
            mode_in     = MODE_INT;
            step_active = 1'b0;
         end else begin
            work_mode = MODE_INT;
         end
      end

      // integer or fraction digit, dot, or terminator
      if (step_active) begin
         if (work_mode == MODE_INT) begin
            if (is_digit) begin
               int_acc_in = int_sum[63:0];
               wrap_in    = wrap_ff || (int_sum[67:64] != 4'd0);
               mode_in    = MODE_INT;
            end else if (is_dot) begin
               mode_in = MODE_FRAC;
            end else begin
               emit = 1'b1;
            end
         end else begin
            if (is_digit) begin
               frac_acc_in = frac_sum[63:0];
               wrap_in     = wrap_ff || (frac_sum[67:64] != 4'd0);
               if (frac_count_ff != COUNT_MAX) begin
                  frac_count_in = frac_count_ff + 8'd1;
               end
            end else begin
               emit          = 1'b1;
               emit_kind     = KIND_FLOAT;
               emit_consumed = is_dot;
            end
         end
      end

      // a closed literal returns the scanner to its start state
      if (emit) begin
         mode_in       = MODE_IDLE;
         radix_in      = RADIX_TEN;
         int_acc_in    = 64'd0;
         frac_acc_in   = 64'd0;
         frac_count_in = 8'd0;
         wrap_in       = 1'b0;
      end
   end

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         radix_ff      <= RADIX_TEN;
         int_acc_ff    <= 64'd0;
         frac_acc_ff   <= 64'd0;
         frac_count_ff <= 8'd0;
         wrap_ff       <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         radix_ff      <= radix_in;
         int_acc_ff    <= int_acc_in;
         frac_acc_ff   <= frac_acc_in;
         frac_count_ff <= frac_count_in;
         wrap_ff       <= wrap_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, taken from the state before the closing character
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff     <= emit_kind;
         rsp_int_ff      <= int_acc_ff;
         rsp_frac_ff     <= (emit_kind == KIND_FLOAT) ? frac_acc_ff : 64'd0;
         rsp_digits_ff   <= (emit_kind == KIND_FLOAT) ? frac_count_ff : 8'd0;
         rsp_radix_ff    <= radix_ff;
         rsp_wrap_ff     <= wrap_ff;
         rsp_consumed_ff <= emit_consumed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_int_value    = rsp_int_ff;
   assign rsp_frac_value   = rsp_frac_ff;
   assign rsp_frac_digits  = rsp_digits_ff;
   assign rsp_radix_code   = rsp_radix_ff;
   assign rsp_overflowed   = rsp_wrap_ff;
   assign rsp_end_consumed = rsp_consumed_ff;

   // checks
   `NLS_ASSERT_NEXT(a_emit_shows, clock, reset, accept && emit, rsp_valid_ff, "token lost after closing item")
   `NLS_ASSERT_NEXT(a_emit_clears, clock, reset, accept && emit, mode_ff == MODE_IDLE && int_acc_ff == 64'd0 && wrap_ff == 1'b0, "scan state not cleared after token")
   `NLS_ASSERT_NOW(a_int_no_frac, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_INT, rsp_frac_ff == 64'd0 && rsp_digits_ff == 8'd0 && rsp_consumed_ff == 1'b0, "integer token carries fraction fields")
   `NLS_ASSERT_NOW(a_radix_mode, clock, reset, radix_ff != RADIX_TEN, mode_ff == MODE_INT || mode_ff == MODE_FRAC, "prefix base set outside digit modes")

endmodule

`default_nettype wire
